// File: hdl/tled_pkg.sv
// Shared types and constants for the two-level event demultiplexer.
`default_nettype none
package tled_pkg;

    localparam int PORT_W = 12;
    localparam int MODE_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_RAISE      = 2'd0,
        MODE_DEMUX      = 2'd1,
        MODE_TEST_CLEAR = 2'd2,
        MODE_UNMASK     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_READ,
        ST_EXEC,
        ST_DM_RD,
        ST_DM_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic dm_start;
        logic div_step;
        logic rem_step;
        logic rd_single;
        logic exec_single;
        logic dm_rd;
        logic dm_wr;
        logic dm_next;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_range;
        logic sel_bit;
        logic idx_last;
        logic out_free;
        logic upcall;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/two_level_event_demux.sv
// Top level of the two-level pending-bitmap event demultiplexer.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    mode, port
//   out       out_valid / out_ready  any_moved, was_flagged, redeliver, upcall_flag
//
// One transaction at a time. Raise, test-and-clear and unmask pass through the
// accept, two reciprocal port-decode steps, one memory read, one read-modify-write
// and one result load; a port beyond the last word skips the read-modify-write.
// Demux passes through the accept, one visit per word, one extra step per selected
// word for its bitmap read before the write-back, and the result load.
// Reset clears all bitmaps at once through per-row valid bits; no clearing pass.
// A stalled result holds in the output register; a finished transaction waits in
// its result load until that register frees, and the next transaction is taken the
// cycle after its result has been loaded there.
`default_nettype none
module two_level_event_demux
#(
    parameter int WORD_BITS = 64,
    parameter int NUM_WORDS = 64
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   mode,
    input  wire logic [tled_pkg::PORT_W-1:0]  port,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              any_moved,
    output logic                              was_flagged,
    output logic                              redeliver,
    output logic                              upcall_flag
);
    import tled_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    mode_t     mode_in;

    assign mode_in = mode_t'(mode);

    tled_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode_in),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tled_dp
    #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .mode        (mode_in),
        .port        (port),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .any_moved   (any_moved),
        .was_flagged (was_flagged),
        .redeliver   (redeliver),
        .upcall_flag (upcall_flag)
    );

    // demux never reports test-and-clear or unmask outcomes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(any_moved && (was_flagged || redeliver)))
        else $error("demux result carries port flags");

    // a demux transaction clears the upcall flag right away
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (mode_in == MODE_DEMUX)) |=> !stat.upcall)
        else $error("upcall flag not cleared by demux");

    // one transaction in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");

endmodule
`default_nettype wire

// File: hdl/tled_ctrl.sv
// Sequencer for raise, demux walk, test-and-clear and unmask transactions.
`default_nettype none
module tled_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire tled_pkg::mode_t       mode,
    output logic                       in_ready,
    input  wire tled_pkg::dp_stat_t    stat,
    output tled_pkg::ctrl_cmd_t        cmd
);
    import tled_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    if (mode == MODE_DEMUX)
                    begin
                        cmd.dm_start = 1'b1;
                        state_next   = ST_DM_RD;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = ST_REM;
            end
            ST_REM:
            begin
                cmd.rem_step = 1'b1;
                state_next   = ST_READ;
            end
            ST_READ:
            begin
                if (stat.in_range)
                begin
                    cmd.rd_single = 1'b1;
                    state_next    = ST_EXEC;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_EXEC:
            begin
                cmd.exec_single = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DM_RD:
            begin
                if (stat.sel_bit)
                begin
                    cmd.dm_rd  = 1'b1;
                    state_next = ST_DM_WR;
                end
                else if (stat.idx_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.dm_next = 1'b1;
                end
            end
            ST_DM_WR:
            begin
                cmd.dm_wr = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.dm_next = 1'b1;
                    state_next  = ST_DM_RD;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/tled_dp.sv
// Datapath: port decode, bitmap memories, selector, upcall flag and result register.
`default_nettype none
module tled_dp
#(
    parameter int WORD_BITS = 64,
    parameter int NUM_WORDS = 64
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tled_pkg::mode_t              mode,
    input  wire logic [tled_pkg::PORT_W-1:0]  port,
    input  wire tled_pkg::ctrl_cmd_t          cmd,
    output tled_pkg::dp_stat_t                stat,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              any_moved,
    output logic                              was_flagged,
    output logic                              redeliver,
    output logic                              upcall_flag
);
    import tled_pkg::*;

    localparam int PORT_MAX = (1 << PORT_W) - 1;
    localparam int QW       = $clog2(PORT_MAX / WORD_BITS + 1);
    localparam int BW       = $clog2(WORD_BITS);
    localparam int IDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int SHIFT    = 24;
    localparam int RECIP    = (1 << SHIFT) / WORD_BITS;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int PROD_W   = PORT_W + RECIP_W;
    localparam int CMP_W    = QW + 7;

    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [PORT_W-1:0]  WB_C    = PORT_W'(WORD_BITS);
    localparam logic [CMP_W-1:0]   NW_C    = CMP_W'(NUM_WORDS);
    localparam logic [IDX_W-1:0]   LAST_C  = IDX_W'(NUM_WORDS - 1);

    logic [WORD_BITS-1:0] pend_mem  [NUM_WORDS];
    logic [WORD_BITS-1:0] mask_mem  [NUM_WORDS];
    logic [WORD_BITS-1:0] hflag_mem [NUM_WORDS];

    logic [NUM_WORDS-1:0] row_vld_reg;
    logic [NUM_WORDS-1:0] selector_reg;
    logic [NUM_WORDS-1:0] sel_reg;
    logic                 upcall_reg;
    logic [IDX_W-1:0]     idx_reg;

    mode_t                mode_reg;
    logic [PORT_W-1:0]    port_reg;
    logic [QW-1:0]        qest_reg;
    logic [IDX_W-1:0]     word_reg;
    logic [BW-1:0]        bit_reg;
    logic                 range_reg;

    logic [WORD_BITS-1:0] pend_rd_reg;
    logic [WORD_BITS-1:0] mask_rd_reg;
    logic [WORD_BITS-1:0] hflag_rd_reg;
    logic                 vld_rd_reg;

    logic                 moved_reg;
    logic                 flagged_reg;
    logic                 redel_reg;

    logic                 out_valid_reg;
    logic                 any_moved_reg;
    logic                 was_flagged_reg;
    logic                 redeliver_reg;
    logic                 upcall_out_reg;

    logic [PROD_W-1:0]    prod1;
    logic [PORT_W-1:0]    prod2;
    logic [PORT_W-1:0]    rem_raw;
    logic                 rem_ge;
    logic [PORT_W-1:0]    rem_fix;
    logic [QW-1:0]        q_fix;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;

    logic [WORD_BITS-1:0] p_cur;
    logic [WORD_BITS-1:0] m_cur;
    logic [WORD_BITS-1:0] h_cur;
    logic [WORD_BITS-1:0] bit_oh;
    logic [WORD_BITS-1:0] mv;

    logic [WORD_BITS-1:0] s_p;
    logic [WORD_BITS-1:0] s_m;
    logic [WORD_BITS-1:0] s_h;
    logic                 s_set_sel;
    logic                 s_flagged;
    logic                 s_redel;
    logic                 s_unmask;

    logic [WORD_BITS-1:0] wr_p;
    logic [WORD_BITS-1:0] wr_m;
    logic [WORD_BITS-1:0] wr_h;

    // port / WORD_BITS by reciprocal; estimate is exact or one low
    assign prod1   = {{RECIP_W{1'b0}}, port_reg} * {{PORT_W{1'b0}}, RECIP_C};
    assign prod2   = {{(PORT_W-QW){1'b0}}, qest_reg} * WB_C;
    assign rem_raw = port_reg - prod2;
    assign rem_ge  = (rem_raw >= WB_C);
    assign rem_fix = rem_ge ? (rem_raw - WB_C) : rem_raw;
    assign q_fix   = rem_ge ? (qest_reg + QW'(1)) : qest_reg;

    assign rd_en   = cmd.rd_single | cmd.dm_rd;
    assign rd_addr = cmd.dm_rd ? idx_reg : word_reg;
    assign wr_en   = cmd.exec_single | cmd.dm_wr;
    assign wr_addr = cmd.dm_wr ? idx_reg : word_reg;

    assign p_cur  = vld_rd_reg ? pend_rd_reg  : '0;
    assign m_cur  = vld_rd_reg ? mask_rd_reg  : '0;
    assign h_cur  = vld_rd_reg ? hflag_rd_reg : '0;
    assign bit_oh = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_reg;
    assign mv     = p_cur & ~m_cur;

    always_comb
    begin
        s_p       = p_cur;
        s_m       = m_cur;
        s_h       = h_cur;
        s_set_sel = 1'b0;
        s_flagged = 1'b0;
        s_redel   = 1'b0;
        s_unmask  = 1'b0;
        case (mode_reg)
            MODE_RAISE:
            begin
                s_p       = p_cur | bit_oh;
                s_set_sel = ((m_cur & bit_oh) == '0);
            end
            MODE_TEST_CLEAR:
            begin
                if ((h_cur & bit_oh) != '0)
                begin
                    s_h       = h_cur & ~bit_oh;
                    s_flagged = 1'b1;
                    s_unmask  = 1'b1;
                end
            end
            MODE_UNMASK:
            begin
                s_unmask = 1'b1;
            end
            default:
            begin
                s_p = p_cur;
            end
        endcase
        if (s_unmask)
        begin
            s_m     = (m_cur & ~bit_oh) | (p_cur & bit_oh);
            s_redel = ((p_cur & bit_oh) != '0);
        end
    end

    assign wr_p = cmd.dm_wr ? (p_cur & ~mv) : s_p;
    assign wr_m = cmd.dm_wr ? (m_cur | mv)  : s_m;
    assign wr_h = cmd.dm_wr ? (h_cur | mv)  : s_h;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pend_mem[wr_addr]  <= wr_p;
            mask_mem[wr_addr]  <= wr_m;
            hflag_mem[wr_addr] <= wr_h;
        end
        if (rd_en)
        begin
            pend_rd_reg  <= pend_mem[rd_addr];
            mask_rd_reg  <= mask_mem[rd_addr];
            hflag_rd_reg <= hflag_mem[rd_addr];
            vld_rd_reg   <= row_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= mode;
            port_reg <= port;
        end
        if (cmd.div_step)
        begin
            qest_reg <= prod1[SHIFT +: QW];
        end
        if (cmd.rem_step)
        begin
            word_reg  <= q_fix[IDX_W-1:0];
            bit_reg   <= rem_fix[BW-1:0];
            range_reg <= (CMP_W'(q_fix) < NW_C);
        end
        if (cmd.dm_start)
        begin
            sel_reg <= selector_reg;
        end
        if (cmd.load_in)
        begin
            moved_reg   <= 1'b0;
            flagged_reg <= 1'b0;
            redel_reg   <= 1'b0;
        end
        else if (cmd.exec_single)
        begin
            flagged_reg <= s_flagged;
            redel_reg   <= s_redel;
        end
        else if (cmd.dm_wr && (mv != '0))
        begin
            moved_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            any_moved_reg   <= moved_reg;
            was_flagged_reg <= flagged_reg;
            redeliver_reg   <= redel_reg;
            upcall_out_reg  <= upcall_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg   <= '0;
            selector_reg  <= '0;
            upcall_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.dm_start)
            begin
                selector_reg <= '0;
                upcall_reg   <= 1'b0;
                idx_reg      <= '0;
            end
            else if (cmd.exec_single && s_set_sel)
            begin
                selector_reg[word_reg] <= 1'b1;
                upcall_reg             <= 1'b1;
            end
            if (cmd.dm_next)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.in_range = range_reg;
    assign stat.sel_bit  = sel_reg[idx_reg];
    assign stat.idx_last = (idx_reg == LAST_C);
    assign stat.out_free = ~out_valid_reg | out_ready;
    assign stat.upcall   = upcall_reg;

    assign out_valid   = out_valid_reg;
    assign any_moved   = any_moved_reg;
    assign was_flagged = was_flagged_reg;
    assign redeliver   = redeliver_reg;
    assign upcall_flag = upcall_out_reg;

endmodule
`default_nettype wire
